[rtl/fbr_pkg.sv]
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared types and constants of the framed packet reassembly receiver.
// ----------------------------------------------------------------------------
package fbr_pkg;

    localparam int STORE_BYTES_DEF     = 4096;
    localparam int MAX_FRAME_BYTES_DEF = 1024;

    localparam int HEADER_W = 8;
    localparam int LIMIT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int PACK_W   = 15;
    localparam int PLEN_W   = 16;
    localparam int SIZE_W   = 13;
    localparam int LIM_W    = 17;

    localparam logic [HEADER_W-1:0] HEADER_RESET = 8'hAA;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 13'd4096;

    localparam logic CFG_HEADER = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam int CTRL_DIR_BIT  = 7;
    localparam int CTRL_TYPE_BIT = 6;
    localparam int FIRST_BIT     = 15;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_HEADER    = 3'd2,
        ST_DIRECTION = 3'd3,
        ST_TYPE      = 3'd4,
        ST_CHECK     = 3'd5,
        ST_OVERFLOW  = 3'd6,
        ST_PACK      = 3'd7
    } status_t;

endpackage

[rtl/fbr_ram.sv]
// ----------------------------------------------------------------------------
// fbr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/framed_packet_reassembly_receiver_core.sv]
// ----------------------------------------------------------------------------
// framed_packet_reassembly_receiver_core
// Frame checker and message reassembly store with byte read-back.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per cycle. s_tuser is the command (0 frame
//   byte, 1 store read), s_tlast marks the last byte of a frame. A frame byte
//   is parsed, checked and, if payload within the limit, stored in the cycle
//   it is taken. Output stream m_*: one item per store read and one per
//   frame-ending byte. Status items appear in the cycle after the input item;
//   read items do too, with the byte from the store's registered read port.
//   Throughput: one item per cycle. Items that give no result are taken even
//   while m_tvalid waits on m_tready; an item that gives a result waits only
//   while the single output register is full and not being taken.
//   Configuration port cfg_*: always ready; index 0 header value, index 1
//   message limit. Write it only while the block is idle.
//   Reset: rst_n clears the receiver to idle, the store logically empty and
//   the registers to their defaults; store contents are not cleared.
// ----------------------------------------------------------------------------
module framed_packet_reassembly_receiver_core
    import fbr_pkg::*;
#(
    parameter int STORE_BYTES     = STORE_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // fields: data_byte[7:0], read_index[19:8], zero fill[23:20]
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,   // command
    input  logic        s_tlast,   // frame_end
    input  logic        s_tvalid,
    output logic        s_tready,
    // fields: status[2:0], message_done[3], message_length[16:4],
    //         read_byte[24:17], zero fill[31:25]
    output logic [31:0] m_tdata,
    output logic        m_tuser,   // result_kind
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int AW    = $clog2(STORE_BYTES);
    localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = ((OFF_W > PLEN_W) ? OFF_W : PLEN_W) + 1;
    localparam int POS_W = CMP_W + 1;

    logic [HEADER_W-1:0] header_reg;
    logic [LIMIT_W-1:0]  limit_reg;

    logic                receiving_reg, receiving_next;
    logic [PACK_W-1:0]   expected_reg, expected_next;
    logic [SIZE_W-1:0]   stored_reg, stored_next;
    logic [OFF_W-1:0]    offset_reg, offset_next;
    logic [7:0]          check_reg, check_next;
    logic [7:0]          ctrl_reg, ctrl_next;
    logic [15:0]         pack_reg, pack_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic                hdr_ok_reg, hdr_ok_next;
    logic                seen_reg, seen_next;
    logic                chk_ok_reg, chk_ok_next;

    logic                out_valid_reg, out_valid_next;
    logic                out_kind_reg, out_kind_next;
    status_t             out_status_reg, out_status_next;
    logic                out_done_reg, out_done_next;
    logic [SIZE_W-1:0]   out_len_reg, out_len_next;
    logic                out_oob_reg, out_oob_next;

    logic [7:0]          data_byte;
    logic [INDEX_W-1:0]  read_index;
    logic                accept;
    logic                is_read;
    logic                is_frame;
    logic                gives_result;
    logic [LIM_W-1:0]    lim;
    logic                active;
    logic [CMP_W-1:0]    idx;
    logic                in_payload;
    logic                at_check;
    logic [POS_W-1:0]    pos;
    logic                ram_we;
    logic [7:0]          ram_rdata;
    logic [7:0]          read_byte;
    logic [PLEN_W:0]     type_sum;
    logic [LIM_W-1:0]    grow_sum;
    logic                first;
    logic [PACK_W-1:0]   num;
    status_t             status;

    assign data_byte  = s_tdata[7:0];
    assign read_index = s_tdata[19:8];

    assign gives_result = s_tuser | s_tlast;
    assign s_tready     = !out_valid_reg || m_tready || !gives_result;
    assign accept       = s_tvalid && s_tready;
    assign is_read      = accept && (s_tuser == CMD_READ);
    assign is_frame     = accept && (s_tuser == CMD_FRAME);
    assign cfg_ready    = 1'b1;

    assign lim = (LIM_W'(limit_reg) > LIM_W'(STORE_BYTES)) ? LIM_W'(STORE_BYTES)
                                                           : LIM_W'(limit_reg);

    assign active     = offset_reg < OFF_W'(MAX_FRAME_BYTES);
    assign idx        = CMP_W'(offset_reg) - CMP_W'(6);
    assign in_payload = (offset_reg >= OFF_W'(6)) && (idx < CMP_W'(plen_reg));
    assign at_check   = (offset_reg >= OFF_W'(6)) && (idx == CMP_W'(plen_reg));
    assign pos        = POS_W'(stored_reg) + POS_W'(idx);
    assign ram_we     = is_frame && active && in_payload && (pos < POS_W'(lim));

    // parse one frame byte
    always_comb
    begin
        offset_next = offset_reg;
        check_next  = check_reg;
        ctrl_next   = ctrl_reg;
        pack_next   = pack_reg;
        plen_next   = plen_reg;
        hdr_ok_next = hdr_ok_reg;
        seen_next   = seen_reg;
        chk_ok_next = chk_ok_reg;
        if (is_frame && active)
        begin
            offset_next = offset_reg + OFF_W'(1);
            if (offset_reg == OFF_W'(0))
            begin
                if (data_byte == header_reg)
                begin
                    hdr_ok_next = 1'b1;
                end
            end
            else if (offset_reg == OFF_W'(1))
            begin
                ctrl_next  = data_byte;
                check_next = data_byte;
            end
            else if (offset_reg <= OFF_W'(5))
            begin
                check_next = check_reg ^ data_byte;
                if (offset_reg == OFF_W'(2))
                begin
                    pack_next[7:0] = data_byte;
                end
                else if (offset_reg == OFF_W'(3))
                begin
                    pack_next[15:8] = data_byte;
                end
                else if (offset_reg == OFF_W'(4))
                begin
                    plen_next[7:0] = data_byte;
                end
                else
                begin
                    plen_next[15:8] = data_byte;
                end
            end
            else if (in_payload)
            begin
                check_next = check_reg ^ data_byte;
            end
            else if (at_check)
            begin
                seen_next = 1'b1;
                if (check_reg == data_byte)
                begin
                    chk_ok_next = 1'b1;
                end
            end
        end
    end

    assign first    = pack_next[FIRST_BIT];
    assign num      = pack_next[PACK_W-1:0];
    assign type_sum = (PLEN_W + 1)'(plen_next) + (PLEN_W + 1)'(7);
    assign grow_sum = LIM_W'(stored_reg) + LIM_W'(plen_next);

    // check the frame in priority order
    always_comb
    begin
        if (offset_next < OFF_W'(7))
        begin
            status = ST_SHORT;
        end
        else if (!hdr_ok_next)
        begin
            status = ST_HEADER;
        end
        else if (ctrl_next[CTRL_DIR_BIT])
        begin
            status = ST_DIRECTION;
        end
        else if (ctrl_next[CTRL_TYPE_BIT])
        begin
            status = ST_TYPE;
        end
        else if (CMP_W'(type_sum) > CMP_W'(offset_next))
        begin
            status = ST_TYPE;
        end
        else if (!seen_next || !chk_ok_next)
        begin
            status = ST_CHECK;
        end
        else if (!receiving_reg && !first)
        begin
            status = ST_PACK;
        end
        else if (receiving_reg && (first || (num != expected_reg)))
        begin
            status = ST_PACK;
        end
        else if (grow_sum > lim)
        begin
            status = ST_OVERFLOW;
        end
        else
        begin
            status = ST_OK;
        end
    end

    // update message state and result register
    always_comb
    begin
        receiving_next  = receiving_reg;
        expected_next   = expected_reg;
        stored_next     = stored_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_done_next   = out_done_reg;
        out_len_next    = out_len_reg;
        out_oob_next    = out_oob_reg;
        if (is_read)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_READ;
            out_status_next = ST_OK;
            out_done_next   = 1'b0;
            out_len_next    = '0;
            out_oob_next    = LIM_W'(read_index) >= LIM_W'(STORE_BYTES);
        end
        else if (is_frame && s_tlast)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = KIND_STATUS;
            out_status_next = status;
            out_done_next   = 1'b0;
            out_len_next    = '0;
            out_oob_next    = 1'b0;
            receiving_next  = 1'b0;
            expected_next   = '0;
            stored_next     = '0;
            if (status == ST_OK)
            begin
                if (num == '0)
                begin
                    out_done_next = 1'b1;
                    out_len_next  = SIZE_W'(grow_sum);
                end
                else
                begin
                    receiving_next = 1'b1;
                    stored_next    = SIZE_W'(grow_sum);
                    expected_next  = num - PACK_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            limit_reg  <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HEADER: header_reg <= cfg_data[HEADER_W-1:0];
                CFG_LIMIT:  limit_reg  <= cfg_data;
                default:    header_reg <= header_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg <= 1'b0;
            expected_reg  <= '0;
            stored_reg    <= '0;
            offset_reg    <= '0;
            check_reg     <= '0;
            ctrl_reg      <= '0;
            pack_reg      <= '0;
            plen_reg      <= '0;
            hdr_ok_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            chk_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            receiving_reg <= receiving_next;
            expected_reg  <= expected_next;
            stored_reg    <= stored_next;
            out_valid_reg <= out_valid_next;
            if (is_frame && s_tlast)
            begin
                offset_reg <= '0;
                check_reg  <= '0;
                ctrl_reg   <= '0;
                pack_reg   <= '0;
                plen_reg   <= '0;
                hdr_ok_reg <= 1'b0;
                seen_reg   <= 1'b0;
                chk_ok_reg <= 1'b0;
            end
            else
            begin
                offset_reg <= offset_next;
                check_reg  <= check_next;
                ctrl_reg   <= ctrl_next;
                pack_reg   <= pack_next;
                plen_reg   <= plen_next;
                hdr_ok_reg <= hdr_ok_next;
                seen_reg   <= seen_next;
                chk_ok_reg <= chk_ok_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_done_reg   <= out_done_next;
        out_len_reg    <= out_len_next;
        out_oob_reg    <= out_oob_next;
    end

    fbr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(pos)),
        .wdata (data_byte),
        .re    (is_read),
        .raddr (AW'(read_index)),
        .rdata (ram_rdata)
    );

    assign read_byte = ((out_kind_reg == KIND_READ) && !out_oob_reg) ? ram_rdata : 8'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, read_byte, out_len_reg, out_done_reg, out_status_reg};

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !receiving_reg |-> (stored_reg == '0) && (expected_reg == '0))
        else $error("idle receiver holds message state");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && gives_result) |=> m_tvalid)
        else $error("result-giving item produced no result");

    a_offset_cap: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= OFF_W'(MAX_FRAME_BYTES))
        else $error("frame offset beyond maximum frame length");

    a_read_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == KIND_READ)) |->
            (out_status_reg == ST_OK) && !out_done_reg && (out_len_reg == '0))
        else $error("read result carries frame status fields");

endmodule

[tb/fbr_result_checker.sv]
// ----------------------------------------------------------------------------
// fbr_result_checker
// Watches the frame/read input stream, the configuration channel and the
// result stream of the reassembly receiver. It keeps its own copy of the
// frame parser, message store and pack sequencing, predicts one status item
// per frame-ending byte and one data item per store read, and compares every
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fbr_result_checker
    import fbr_pkg::*;
#(
    parameter int STORE_BYTES     = STORE_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [23:0]            s_tdata,
    input  logic                   s_tuser,
    input  logic                   s_tlast,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [31:0]            m_tdata,
    input  logic                   m_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic                   cfg_index,
    input  logic [12:0]            cfg_data,
    output int                     failures,
    output int                     pending,
    output logic [STORE_BYTES-1:0] stored_mask
);

    typedef struct {
        logic              kind;
        status_t           status;
        logic              done;
        logic [SIZE_W-1:0] length;
        logic [7:0]        rbyte;
    } result_t;

    logic [HEADER_W-1:0] header_value;
    logic [LIMIT_W-1:0]  message_limit;

    logic               receiving;
    logic [PACK_W-1:0]  expected_pack;
    int                 stored_size;
    logic [7:0]         store_mem [STORE_BYTES];

    int                 frame_len;
    logic [7:0]         xor_acc;
    logic [7:0]         ctrl_byte;
    logic [15:0]        pack_ctrl;
    int                 pay_count;
    logic               header_ok;
    logic               check_seen;
    logic               check_ok;

    result_t            expected_results [$];
    int                 mismatches;

    function automatic int limit_now();
        return (message_limit > STORE_BYTES) ? STORE_BYTES : int'(message_limit);
    endfunction

    task automatic clear_frame();
        frame_len  = 0;
        xor_acc    = '0;
        ctrl_byte  = '0;
        pack_ctrl  = '0;
        pay_count  = 0;
        header_ok  = 1'b0;
        check_seen = 1'b0;
        check_ok   = 1'b0;
    endtask

    task automatic go_idle();
        receiving     = 1'b0;
        expected_pack = '0;
        stored_size   = 0;
    endtask

    task automatic take_frame_byte(input logic [7:0] b);
        int pos;
        if (frame_len >= MAX_FRAME_BYTES)
            return;
        if (frame_len == 0)
        begin
            header_ok = (b == header_value);
        end
        else if (frame_len == 1)
        begin
            ctrl_byte = b;
            xor_acc   = b;
        end
        else if (frame_len <= 3)
        begin
            pack_ctrl[(frame_len - 2) * 8 +: 8] = b;
            xor_acc = xor_acc ^ b;
        end
        else if (frame_len <= 5)
        begin
            pay_count = pay_count | (int'(b) << ((frame_len - 4) * 8));
            xor_acc = xor_acc ^ b;
        end
        else if (frame_len - 6 < pay_count)
        begin
            pos     = stored_size + frame_len - 6;
            xor_acc = xor_acc ^ b;
            if (pos < limit_now())
            begin
                store_mem[pos]   = b;
                stored_mask[pos] <= 1'b1;
            end
        end
        else if (frame_len - 6 == pay_count)
        begin
            check_seen = 1'b1;
            check_ok   = (xor_acc == b);
        end
        frame_len++;
    endtask

    task automatic close_frame(output result_t r);
        logic              first;
        logic [PACK_W-1:0] num;
        status_t           st;
        first    = pack_ctrl[FIRST_BIT];
        num      = pack_ctrl[PACK_W-1:0];
        r.kind   = KIND_STATUS;
        r.done   = 1'b0;
        r.length = '0;
        r.rbyte  = '0;
        if (frame_len < 7)
            st = ST_SHORT;
        else if (!header_ok)
            st = ST_HEADER;
        else if (ctrl_byte[CTRL_DIR_BIT])
            st = ST_DIRECTION;
        else if (ctrl_byte[CTRL_TYPE_BIT] || pay_count > frame_len - 7)
            st = ST_TYPE;
        else if (!(check_seen && check_ok))
            st = ST_CHECK;
        else if (!receiving && !first)
            st = ST_PACK;
        else if (receiving && (first || num != expected_pack))
            st = ST_PACK;
        else if (stored_size + pay_count > limit_now())
            st = ST_OVERFLOW;
        else
            st = ST_OK;
        if (st != ST_OK)
        begin
            go_idle();
        end
        else
        begin
            stored_size += pay_count;
            if (num == 0)
            begin
                r.done   = 1'b1;
                r.length = SIZE_W'(stored_size);
                go_idle();
            end
            else if (!receiving)
            begin
                expected_pack = num - 1'b1;
                receiving     = 1'b1;
            end
            else if (expected_pack != 0)
            begin
                expected_pack = expected_pack - 1'b1;
            end
        end
        r.status = st;
        clear_frame();
    endtask

    task automatic predict_item();
        result_t     r;
        logic [11:0] idx;
        if (s_tuser == CMD_READ)
        begin
            idx      = s_tdata[19:8];
            r.kind   = KIND_READ;
            r.status = ST_OK;
            r.done   = 1'b0;
            r.length = '0;
            r.rbyte  = (int'(idx) < STORE_BYTES) ? store_mem[idx] : 8'h00;
            expected_results.push_back(r);
        end
        else
        begin
            take_frame_byte(s_tdata[7:0]);
            if (s_tlast)
            begin
                close_frame(r);
                expected_results.push_back(r);
            end
        end
    endtask

    task automatic compare_result();
        result_t r;
        if (expected_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d tdata %08h", m_tuser, m_tdata);
        end
        else
        begin
            r = expected_results.pop_front();
            if (m_tuser !== r.kind || m_tdata[2:0] !== r.status || m_tdata[3] !== r.done
                || m_tdata[16:4] !== r.length || m_tdata[24:17] !== r.rbyte
                || m_tdata[31:25] !== 7'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp kind %0d status %0d done %0d len %0d ",
                              "byte %02h, got kind %0d status %0d done %0d len %0d ",
                              "byte %02h fill %02h"},
                             r.kind, r.status, r.done, r.length, r.rbyte,
                             m_tuser, m_tdata[2:0], m_tdata[3], m_tdata[16:4],
                             m_tdata[24:17], m_tdata[31:25]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value  = HEADER_RESET;
            message_limit = LIMIT_RESET;
            go_idle();
            clear_frame();
            expected_results.delete();
            mismatches  = 0;
            failures    <= 0;
            pending     <= 0;
            stored_mask <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                compare_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HEADER)
                    header_value = cfg_data[HEADER_W-1:0];
                else
                    message_limit = cfg_data;
            end
            if (s_tvalid && s_tready)
                predict_item();
            pending  <= expected_results.size();
            failures <= mismatches;
        end
    end

endmodule

[tb/tb_framed_packet_reassembly_receiver_core.sv]
// ----------------------------------------------------------------------------
// tb_framed_packet_reassembly_receiver_core
// Drives frames and store reads into the reassembly receiver under bursty
// input and a stalling result consumer. A directed set covers each frame
// error, pack sequencing, overflow at small limits, an overlong frame and a
// message that fills the whole store; random messages, broken frames, noise
// and reads follow under several header and limit settings.
// ----------------------------------------------------------------------------
module tb_framed_packet_reassembly_receiver_core;
    import fbr_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {
        MUT_NONE,
        MUT_TRUNC,
        MUT_HEADER,
        MUT_DIR,
        MUT_TYPE,
        MUT_CHECK,
        MUT_PACK
    } fault_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic [23:0] s_tdata   = '0;
    logic        s_tuser   = CMD_FRAME;
    logic        s_tlast   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_HEADER;
    logic [12:0] cfg_data  = '0;

    int                        failures;
    int                        pending;
    logic [STORE_BYTES_DEF-1:0] stored_mask;

    int         sent        = 0;
    int         burst_left  = 0;
    int         cycle_count = 0;
    int         stall_left  = 0;
    int         stall_mode  = 0;
    bit         mix_reads   = 1'b0;
    logic [7:0] header_now  = HEADER_RESET;
    logic [7:0] frame_q [$];

    always #4 clk = ~clk;

    framed_packet_reassembly_receiver_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fbr_result_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .pending     (pending),
        .stored_mask (stored_mask)
    );

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("tb_framed_packet_reassembly_receiver_core: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 80);
        end
        stall_left--;
        case (stall_mode)
            0, 1: m_tready <= 1'b1;
            2: m_tready <= ($urandom_range(0, 1) == 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_item(input logic cmd, input logic [7:0] data, input logic last,
                             input logic [11:0] idx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {4'h0, idx, data};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    function automatic int pick_index();
        int start;
        int k;
        start = $urandom_range(0, STORE_BYTES_DEF - 1);
        for (k = 0; k < STORE_BYTES_DEF; k++)
            if (stored_mask[(start + k) % STORE_BYTES_DEF])
                return (start + k) % STORE_BYTES_DEF;
        return -1;
    endfunction

    task automatic send_read();
        int idx;
        idx = pick_index();
        if (idx >= 0)
            send_item(CMD_READ, 8'($urandom), 1'($urandom_range(0, 1)), 12'(idx));
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++) begin
            if (mix_reads && $urandom_range(0, 15) == 0)
                send_read();
            send_item(CMD_FRAME, frame_q[i], i == frame_q.size() - 1, 12'($urandom));
        end
    endtask

    task automatic build_frame(input logic [7:0] ctrl, input logic [15:0] pctl,
                               input logic [15:0] plen, input int npay);
        logic [7:0] chk;
        logic [7:0] b;
        int         i;
        frame_q.delete();
        chk = ctrl ^ pctl[7:0] ^ pctl[15:8] ^ plen[7:0] ^ plen[15:8];
        frame_q.push_back(header_now);
        frame_q.push_back(ctrl);
        frame_q.push_back(pctl[7:0]);
        frame_q.push_back(pctl[15:8]);
        frame_q.push_back(plen[7:0]);
        frame_q.push_back(plen[15:8]);
        for (i = 0; i < npay; i++) begin
            b   = 8'($urandom);
            chk = chk ^ b;
            frame_q.push_back(b);
        end
        frame_q.push_back(chk);
    endtask

    task automatic add_fill(input int n);
        repeat (n) frame_q.push_back(8'($urandom));
    endtask

    task automatic truncate_to(input int n);
        while (frame_q.size() > n) void'(frame_q.pop_back());
    endtask

    task automatic apply_fault(input fault_t f);
        case (f)
            MUT_TRUNC: truncate_to($urandom_range(1, frame_q.size() - 1));
            MUT_HEADER: frame_q[0] = header_now ^ 8'($urandom_range(1, 255));
            MUT_DIR: frame_q[1] = frame_q[1] | 8'h80;
            MUT_TYPE: frame_q[1] = frame_q[1] | 8'h40;
            MUT_CHECK: frame_q[frame_q.size() - 1] = frame_q[frame_q.size() - 1]
                                                     ^ 8'($urandom_range(1, 255));
            default: ;
        endcase
    endtask

    task automatic send_message(input int npacks, input int first_num, input int max_len,
                                input bit faults);
        logic [15:0] pctl;
        int          npay;
        int          p;
        fault_t      f;
        for (p = 0; p < npacks; p++) begin
            f = MUT_NONE;
            if (faults && $urandom_range(0, 9) == 0)
                f = fault_t'($urandom_range(MUT_TRUNC, MUT_PACK));
            pctl = ((p == 0) ? 16'h8000 : 16'h0000) | 16'((first_num - p) & 32'h7FFF);
            if (f == MUT_PACK)
                pctl = pctl ^ (16'h0001 << $urandom_range(0, 15));
            npay = $urandom_range(0, max_len);
            build_frame(8'($urandom_range(0, 63)), pctl, 16'(npay), npay);
            if (f != MUT_NONE && f != MUT_PACK)
                apply_fault(f);
            if (f != MUT_TRUNC)
                add_fill($urandom_range(0, 2));
            send_frame();
            if (mix_reads && $urandom_range(0, 3) == 0)
                send_read();
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] hdr, input logic [12:0] lim);
        drain();
        cfg_write(CFG_HEADER, {5'd0, hdr});
        cfg_write(CFG_LIMIT, lim);
        header_now = hdr;
    endtask

    task automatic random_round();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            n = $urandom_range(1, 4);
            send_message(n, n - 1, 12, 1'b1);
        end else if (r < 70) begin
            n = $urandom_range(1, 2);
            send_message(n, $urandom_range(n - 1, 32767), 12, 1'b1);
        end else if (r < 85) begin
            repeat ($urandom_range(1, 4)) send_read();
        end else begin
            frame_q.delete();
            add_fill($urandom_range(1, 12));
            if ($urandom_range(0, 1) == 1)
                frame_q[0] = header_now;
            send_frame();
        end
    endtask

    initial
    begin
        int ph;
        int target;
        logic [7:0]  hdr;
        logic [12:0] lim;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(HEADER_RESET, LIMIT_RESET);

        build_frame(8'h00, 16'h8000, 16'd0, 0);
        send_frame();
        build_frame(8'h3F, 16'h8000, 16'd2, 2);
        truncate_to(3);
        send_frame();
        build_frame(8'h00, 16'h8000, 16'd1, 1);
        apply_fault(MUT_HEADER);
        send_frame();
        build_frame(8'h00, 16'h8000, 16'd1, 1);
        apply_fault(MUT_DIR);
        send_frame();
        build_frame(8'h00, 16'h8000, 16'd1, 1);
        apply_fault(MUT_TYPE);
        send_frame();
        build_frame(8'h01, 16'h8000, 16'd5, 2);
        send_frame();
        build_frame(8'h00, 16'h8000, 16'd2, 2);
        apply_fault(MUT_CHECK);
        send_frame();
        build_frame(8'h00, 16'h0001, 16'd3, 3);
        send_frame();
        build_frame(8'h12, 16'h8001, 16'd3, 3);
        send_frame();
        build_frame(8'h21, 16'h0000, 16'd2, 2);
        add_fill(2);
        send_frame();
        build_frame(8'h00, 16'h8002, 16'd1, 1);
        send_frame();
        build_frame(8'h00, 16'h8001, 16'd1, 1);
        send_frame();
        build_frame(8'h00, 16'h8002, 16'd1, 1);
        send_frame();
        build_frame(8'h00, 16'h0000, 16'd1, 1);
        send_frame();
        repeat (4) send_read();

        set_config(8'hFF, 13'd4);
        build_frame(8'h00, 16'h8000, 16'd5, 5);
        send_frame();
        build_frame(8'h00, 16'h8000, 16'd4, 4);
        send_frame();
        set_config(8'h00, 13'd1);
        build_frame(8'h00, 16'h8000, 16'd1, 1);
        send_frame();

        // fill the whole store in one message; the first pack runs past the frame limit
        set_config(HEADER_RESET, LIMIT_RESET);
        build_frame(8'h05, 16'h8004, 16'd1017, 1017);
        add_fill(8);
        send_frame();
        build_frame(8'h06, 16'h0003, 16'd1017, 1017);
        send_frame();
        build_frame(8'h07, 16'h0002, 16'd1017, 1017);
        send_frame();
        build_frame(8'h08, 16'h0001, 16'd1017, 1017);
        send_frame();
        build_frame(8'h09, 16'h0000, 16'd28, 28);
        send_frame();
        repeat (8) send_read();

        mix_reads = 1'b1;
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin hdr = HEADER_RESET; lim = LIMIT_RESET; end
                1: begin hdr = 8'h00; lim = 13'd1; end
                2: begin hdr = 8'hFF; lim = 13'd24; end
                default: begin hdr = 8'($urandom); lim = 13'($urandom_range(1, 64)); end
            endcase
            set_config(hdr, lim);
            target = sent + 200;
            while (sent < target) random_round();
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0)
            $display("tb_framed_packet_reassembly_receiver_core: PASS");
        else
            $display("tb_framed_packet_reassembly_receiver_core: FAIL");
        $finish;
    end

endmodule
